// ----- rtl/core/constant_divisor_magic_number_assert.svh -----
// Assertion macros for the constant divisor magic number block.
`ifndef CONSTANT_DIVISOR_MAGIC_NUMBER_ASSERT_SVH
`define CONSTANT_DIVISOR_MAGIC_NUMBER_ASSERT_SVH

// Check an implication on the rising clock edge outside reset.
`define CDMN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a signal holds while the master side stalls.
`define CDMN_ASSERT_HOLD(label, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(sig))) \
    else $error(msg);

`endif

// ----- rtl/core/cdmn_pkg.sv -----
// Shared types and constants for the constant divisor magic number block.
package cdmn_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned LogW      = 5;
  localparam int unsigned QuotW     = 33;
  localparam int unsigned CntW      = 6;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned PrecBits  = 31;

  typedef enum logic [1:0] {
    STRAT_IDENT  = 2'd0,
    STRAT_POW2   = 2'd1,
    STRAT_MULHI  = 2'd2,
    STRAT_MULACC = 2'd3
  } strat_e;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

endpackage

// ----- rtl/core/cdmn_bitlen.sv -----
// Bit-serial bit-length counter: shifts the value right one bit per cycle.
module cdmn_bitlen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cdmn_pkg::DataW-1:0]    val_i,
  output logic                          done_o,
  output logic [cdmn_pkg::LogW-1:0]     len_o
);

  logic                          busy_q, busy_d;
  logic [cdmn_pkg::DataW-1:0]    val_q;
  logic [cdmn_pkg::LogW-1:0]     len_q;

  assign done_o = busy_q && (val_q == '0);
  assign len_o  = len_q;

  always_comb begin
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= val_i;
      len_q <= '0;
    end else if (busy_q && (val_q != '0)) begin
      val_q <= val_q >> 1;
      len_q <= len_q + cdmn_pkg::LogW'(1);
    end
  end

endmodule

// ----- rtl/core/cdmn_div.sv -----
// Radix-2 restoring divider for 2^(31+l) by |d|, with the high quotient fixup.
module cdmn_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cdmn_pkg::DataW-1:0]    mag_i,
  input  logic [cdmn_pkg::LogW-1:0]     log_i,
  output logic                          done_o,
  output logic [cdmn_pkg::QuotW-1:0]    q_low_o,
  output logic [cdmn_pkg::QuotW-1:0]    q_high_o
);

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_DIV  = 4'b0010,
    DV_PREP = 4'b0100,
    DV_FIX  = 4'b1000
  } dv_state_e;

  dv_state_e                       state_q, state_d;
  logic [cdmn_pkg::CntW-1:0]       cnt_q;
  logic [cdmn_pkg::LogW-1:0]       log_q;
  logic [cdmn_pkg::QuotW-1:0]      rem_q;
  logic [cdmn_pkg::QuotW-1:0]      q_lo_q;
  logic [cdmn_pkg::QuotW-1:0]      q_hi_q;
  logic [cdmn_pkg::QuotW-1:0]      mag_ext;
  logic [cdmn_pkg::QuotW-1:0]      trial;
  logic                            fits;
  logic                            fix_ge;

  assign mag_ext  = {1'b0, mag_i};
  assign trial    = {rem_q[cdmn_pkg::QuotW-2:0], 1'b0};
  assign fits     = trial >= mag_ext;
  assign fix_ge   = rem_q >= mag_ext;
  assign done_o   = (state_q == DV_FIX) && !fix_ge;
  assign q_low_o  = q_lo_q;
  assign q_high_o = q_hi_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          state_d = DV_DIV;
        end
      end
      DV_DIV: begin
        if (cnt_q == cdmn_pkg::CntW'(1)) begin
          state_d = DV_PREP;
        end
      end
      DV_PREP: begin
        state_d = DV_FIX;
      end
      DV_FIX: begin
        if (!fix_ge) begin
          state_d = DV_IDLE;
        end
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == DV_IDLE) && start_i) begin
      rem_q  <= cdmn_pkg::QuotW'(1);
      q_lo_q <= '0;
      log_q  <= log_i;
      cnt_q  <= cdmn_pkg::CntW'(cdmn_pkg::PrecBits) + {1'b0, log_i};
    end else if (state_q == DV_DIV) begin
      cnt_q  <= cnt_q - cdmn_pkg::CntW'(1);
      rem_q  <= fits ? (trial - mag_ext) : trial;
      q_lo_q <= {q_lo_q[cdmn_pkg::QuotW-2:0], fits};
    end else if (state_q == DV_PREP) begin
      rem_q  <= rem_q + (cdmn_pkg::QuotW'(1) << log_q);
      q_hi_q <= q_lo_q;
    end else if ((state_q == DV_FIX) && fix_ge) begin
      rem_q  <= rem_q - mag_ext;
      q_hi_q <= q_hi_q + cdmn_pkg::QuotW'(1);
    end
  end

endmodule

// ----- rtl/core/cdmn_halve.sv -----
// Halving loop: drops one bit of both quotients per cycle while their halves still differ and the shift is above one.
module cdmn_halve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cdmn_pkg::QuotW-1:0]    m_low_i,
  input  logic [cdmn_pkg::QuotW-1:0]    m_high_i,
  input  logic [cdmn_pkg::LogW-1:0]     log_i,
  output logic                          done_o,
  output logic [cdmn_pkg::DataW-1:0]    magic_o,
  output logic [cdmn_pkg::LogW-1:0]     shift_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [cdmn_pkg::QuotW-1:0]    lo_q;
  logic [cdmn_pkg::QuotW-1:0]    hi_q;
  logic [cdmn_pkg::LogW-1:0]     sh_q;
  logic                          step;

  assign step    = (lo_q[cdmn_pkg::QuotW-1:1] < hi_q[cdmn_pkg::QuotW-1:1])
                   && (sh_q > cdmn_pkg::LogW'(1));
  assign done_o  = done_q;
  assign magic_o = hi_q[cdmn_pkg::DataW-1:0];
  assign shift_o = sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && !step) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lo_q <= m_low_i;
      hi_q <= m_high_i;
      sh_q <= log_i;
    end else if (busy_q) begin
      sh_q <= sh_q - cdmn_pkg::LogW'(1);
      if (step) begin
        lo_q <= lo_q >> 1;
        hi_q <= hi_q >> 1;
      end
    end
  end

endmodule

// ----- rtl/core/constant_divisor_magic_number.sv -----
// Top level: signed constant-divisor magic number generator.
// Usage:
//   The slave channel takes one signed 32-bit divisor per request. The
//   master channel returns one result per request: status, strategy class,
//   32-bit magic multiplier, post shift, ceiling log2 of |d| and negate flag.
//   Zero and the most negative value return status invalid, all else zero.
//   A unit magnitude returns the identity strategy with magic and shifts 0.
// Flow:
//   One request at a time. Invalid and unit divisors skip the core and go
//   straight to the result. Others pass through a bit-serial length count
//   of |d| - 1 (l = ceiling log2 of |d|, up to 31), one radix-2 divider
//   step per quotient bit for 31 + l quotient bits, a fixup of the upper
//   quotient, and a halving loop.
// Reset and stall:
//   Reset empties the core and the output register. A finished result waits
//   in the output register while the master side stalls; the next request is
//   taken and worked on meanwhile, and its result is held inside until the
//   output register frees up.
module constant_divisor_magic_number (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // divisor[31:0]
  input  logic [cdmn_pkg::InTdataW-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status[0], strategy[2:1], magic[34:3], post_shift[39:35],
  // log_ceil[44:40], negate[45], zero fill[47:46]
  output logic [cdmn_pkg::OutTdataW-1:0]      m_axis_tdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LEN   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_HALVE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic                            in_acc;
  logic                            out_load;
  logic [cdmn_pkg::DataW-1:0]      raw;
  logic                            raw_neg;
  logic                            raw_invalid;
  logic [cdmn_pkg::DataW-1:0]      mag_m1;
  logic                            unit_mag;

  logic [cdmn_pkg::DataW-1:0]      mag_q;
  logic                            neg_q;
  logic [cdmn_pkg::LogW-1:0]       l_q;

  logic                            res_status_q;
  cdmn_pkg::strat_e                res_strat_q;
  logic [cdmn_pkg::DataW-1:0]      res_magic_q;
  logic [cdmn_pkg::LogW-1:0]       res_shift_q;
  logic [cdmn_pkg::LogW-1:0]       res_log_q;
  logic                            res_neg_q;

  logic                            out_valid_q;
  logic                            out_status_q;
  cdmn_pkg::strat_e                out_strat_q;
  logic [cdmn_pkg::DataW-1:0]      out_magic_q;
  logic [cdmn_pkg::LogW-1:0]       out_shift_q;
  logic [cdmn_pkg::LogW-1:0]       out_log_q;
  logic                            out_neg_q;

  logic                            bl_start;
  logic                            bl_done;
  logic [cdmn_pkg::LogW-1:0]       bl_len;
  logic                            dv_start;
  logic                            dv_done;
  logic [cdmn_pkg::QuotW-1:0]      dv_q_low;
  logic [cdmn_pkg::QuotW-1:0]      dv_q_high;
  logic                            hv_start;
  logic                            hv_done;
  logic [cdmn_pkg::DataW-1:0]      hv_magic;
  logic [cdmn_pkg::LogW-1:0]       hv_shift;
  cdmn_pkg::strat_e                hv_strat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign raw         = s_axis_tdata[cdmn_pkg::DataW-1:0];
  assign raw_neg     = raw[cdmn_pkg::DataW-1];
  assign raw_invalid = (raw == '0) || (raw == {1'b1, {(cdmn_pkg::DataW-1){1'b0}}});
  assign mag_m1      = raw_neg ? ~raw : (raw - cdmn_pkg::DataW'(1));
  assign unit_mag    = (mag_m1 == '0);

  assign bl_start = in_acc && !raw_invalid && !unit_mag;
  assign dv_start = (state_q == ST_LEN) && bl_done;
  assign hv_start = (state_q == ST_DIV) && dv_done;

  always_comb begin
    if (mag_q == (cdmn_pkg::DataW'(1) << l_q)) begin
      hv_strat = cdmn_pkg::STRAT_POW2;
    end else if (hv_magic[cdmn_pkg::DataW-1]) begin
      hv_strat = cdmn_pkg::STRAT_MULACC;
    end else begin
      hv_strat = cdmn_pkg::STRAT_MULHI;
    end
  end

  cdmn_bitlen u_bitlen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bl_start),
    .val_i   (mag_m1),
    .done_o  (bl_done),
    .len_o   (bl_len)
  );

  cdmn_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (dv_start),
    .mag_i    (mag_q),
    .log_i    (bl_len),
    .done_o   (dv_done),
    .q_low_o  (dv_q_low),
    .q_high_o (dv_q_high)
  );

  cdmn_halve u_halve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hv_start),
    .m_low_i  (dv_q_low),
    .m_high_i (dv_q_high),
    .log_i    (l_q),
    .done_o   (hv_done),
    .magic_o  (hv_magic),
    .shift_o  (hv_shift)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (raw_invalid || unit_mag) ? ST_DONE : ST_LEN;
        end
      end
      ST_LEN: begin
        if (bl_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          state_d = ST_HALVE;
        end
      end
      ST_HALVE: begin
        if (hv_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_q       <= mag_m1 + cdmn_pkg::DataW'(1);
      neg_q       <= raw_neg;
    end
    if (in_acc && (raw_invalid || unit_mag)) begin
      res_status_q <= raw_invalid ? cdmn_pkg::STATUS_INVALID : cdmn_pkg::STATUS_OK;
      res_strat_q  <= cdmn_pkg::STRAT_IDENT;
      res_magic_q  <= '0;
      res_shift_q  <= '0;
      res_log_q    <= '0;
      res_neg_q    <= raw_neg && !raw_invalid;
    end
    if (dv_start) begin
      l_q <= bl_len;
    end
    if ((state_q == ST_HALVE) && hv_done) begin
      res_status_q <= cdmn_pkg::STATUS_OK;
      res_strat_q  <= hv_strat;
      res_magic_q  <= hv_magic;
      res_shift_q  <= hv_shift;
      res_log_q    <= l_q;
      res_neg_q    <= neg_q;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_strat_q  <= res_strat_q;
      out_magic_q  <= res_magic_q;
      out_shift_q  <= res_shift_q;
      out_log_q    <= res_log_q;
      out_neg_q    <= res_neg_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_neg_q, out_log_q, out_shift_q, out_magic_q,
                          out_strat_q, out_status_q};

endmodule

// ----- rtl/core/cdmn_checker.sv -----
// Port-level checker for the constant divisor magic number block, with its bind.
`include "constant_divisor_magic_number_assert.svh"

module cdmn_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [cdmn_pkg::OutTdataW-1:0]      m_axis_tdata
);

  logic                            chk_status;
  logic [1:0]                      chk_strat;
  logic [cdmn_pkg::DataW-1:0]      chk_magic;
  logic [cdmn_pkg::LogW-1:0]       chk_shift;
  logic [cdmn_pkg::LogW-1:0]       chk_log;
  logic                            in_acc;

  assign chk_status = m_axis_tdata[0];
  assign chk_strat  = m_axis_tdata[2:1];
  assign chk_magic  = m_axis_tdata[34:3];
  assign chk_shift  = m_axis_tdata[39:35];
  assign chk_log    = m_axis_tdata[44:40];
  assign in_acc     = s_axis_tvalid && s_axis_tready;

  `CDMN_ASSERT_HOLD(a_out_hold, m_axis_tdata, "result changed while stalled")

  `CDMN_ASSERT(a_busy_after_req, in_acc |=> !s_axis_tready,
    "request taken while the previous one is still in work")

  `CDMN_ASSERT(a_invalid_clear,
    (m_axis_tvalid && (chk_status == cdmn_pkg::STATUS_INVALID))
      |-> (m_axis_tdata[cdmn_pkg::OutTdataW-1:1] == '0),
    "invalid divisor result carries nonzero fields")

  `CDMN_ASSERT(a_strat_magic,
    (m_axis_tvalid && (chk_status == cdmn_pkg::STATUS_OK) && chk_strat[1])
      |-> (chk_magic[cdmn_pkg::DataW-1] == chk_strat[0]),
    "multiply strategy disagrees with magic sign bit")

  `CDMN_ASSERT(a_shift_below_log,
    (m_axis_tvalid && (chk_status == cdmn_pkg::STATUS_OK)
      && (chk_strat != cdmn_pkg::STRAT_IDENT)) |-> (chk_shift < chk_log),
    "post shift not below log ceiling")

endmodule

bind constant_divisor_magic_number cdmn_checker u_cdmn_checker (.*);
